// ===== rtl/core/lpfr_pkg.sv =====
// ---------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants for the length-prefixed frame receiver.
// ---------------------------------------------------------------------------
package lpfr_pkg;

	localparam logic [7:0] MAX_PAYLOAD_RST = 8'd255;

	typedef enum logic [2:0] {
		PH_SIZE  = 3'd0,
		PH_TYPE  = 3'd1,
		PH_DATA  = 3'd2,
		PH_INDEX = 3'd3,
		PH_CHECK = 3'd4
	} phase_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_offset;
		logic [7:0] frame_type;
		logic [7:0] frame_index;
		logic [7:0] frame_length;
		logic       checksum_ok;
		logic       oversize;
	} res_t;

	typedef struct packed {
		logic has_result;
		res_t res;
	} parse_out_t;

endpackage

// ===== rtl/core/lpfr_chan_if.sv =====
// ---------------------------------------------------------------------------
// lpfr_chan_if
// Valid/ready channel carrying one payload of type T per transfer.
// ---------------------------------------------------------------------------
interface lpfr_chan_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lpfr_in_stage.sv =====
// ---------------------------------------------------------------------------
// lpfr_in_stage
// Input register for received link bytes.
// ---------------------------------------------------------------------------
module lpfr_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	output logic       in_ready,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	assign in_ready = arst_n & (~valid_s1 | advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end
endmodule

// ===== rtl/core/lpfr_parser.sv =====
// ---------------------------------------------------------------------------
// lpfr_parser
// Frame parse state and per-byte result logic.
// ---------------------------------------------------------------------------
module lpfr_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            byte_s1,
	input  logic                  fire,
	input  logic [7:0]            max_payload,
	output lpfr_pkg::parse_out_t  po
);
	lpfr_pkg::phase_t phase_q, phase_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] offset_q, offset_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] length_q, length_d;
	logic [7:0] type_q, type_d;
	logic [7:0] index_q, index_d;

	always_comb begin
		po          = '0;
		phase_d     = phase_q;
		remaining_d = remaining_q;
		offset_d    = offset_q;
		sum_d       = sum_q;
		length_d    = length_q;
		type_d      = type_q;
		index_d     = index_q;
		case (phase_q)
			lpfr_pkg::PH_TYPE: begin
				type_d  = byte_s1;
				phase_d = (length_q != 8'd0) ? lpfr_pkg::PH_DATA : lpfr_pkg::PH_INDEX;
			end
			lpfr_pkg::PH_DATA: begin
				if (offset_q < max_payload) begin
					po.has_result         = 1'b1;
					po.res.result_kind    = lpfr_pkg::KIND_PAYLOAD;
					po.res.payload_byte   = byte_s1;
					po.res.payload_offset = offset_q;
				end
				sum_d       = sum_q + byte_s1;
				offset_d    = offset_q + 8'd1;
				remaining_d = remaining_q - 8'd1;
				if (remaining_q == 8'd1) begin
					phase_d = lpfr_pkg::PH_INDEX;
				end
			end
			lpfr_pkg::PH_INDEX: begin
				index_d = byte_s1;
				phase_d = lpfr_pkg::PH_CHECK;
			end
			lpfr_pkg::PH_CHECK: begin
				po.has_result       = 1'b1;
				po.res.result_kind  = lpfr_pkg::KIND_SUMMARY;
				po.res.frame_type   = type_q;
				po.res.frame_index  = index_q;
				po.res.frame_length = length_q;
				po.res.checksum_ok  = (length_q == 8'd0) || (sum_q == byte_s1);
				po.res.oversize     = length_q > max_payload;
				phase_d             = lpfr_pkg::PH_SIZE;
			end
			default: begin
				length_d    = byte_s1;
				remaining_d = byte_s1;
				offset_d    = 8'd0;
				sum_d       = 8'd0;
				phase_d     = lpfr_pkg::PH_TYPE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lpfr_pkg::PH_SIZE;
			remaining_q <= 8'd0;
			offset_q    <= 8'd0;
			sum_q       <= 8'd0;
			length_q    <= 8'd0;
			type_q      <= 8'd0;
			index_q     <= 8'd0;
		end else if (fire) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			offset_q    <= offset_d;
			sum_q       <= sum_d;
			length_q    <= length_d;
			type_q      <= type_d;
			index_q     <= index_d;
		end
	end
endmodule

// ===== rtl/core/lpfr_out_reg.sv =====
// ---------------------------------------------------------------------------
// lpfr_out_reg
// Result register holding one item until the sink takes it.
// ---------------------------------------------------------------------------
module lpfr_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  lpfr_pkg::res_t load_data,
	output logic           can_load,
	output logic           out_valid,
	input  logic           out_ready,
	output lpfr_pkg::res_t out_data
);
	logic           valid_q;
	lpfr_pkg::res_t data_q;

	assign can_load  = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end
endmodule

// ===== rtl/core/length_prefixed_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Parses size/type/payload/index/checksum frames from a byte stream,
// forwarding payload bytes below max_payload and emitting a summary per frame.
//
//   channel  role    payload            transfer
//   rx       sink    received byte      one byte per transfer
//   res      source  lpfr_pkg::res_t    payload byte or frame summary
//   cfg      sink    max_payload byte   register write
//
// One byte per cycle sustained unless a result stalls at the result register;
// a result passes through the input register and then the result register.
// Reset clears the parse state and sets max_payload to 255.
// A stalled result holds the byte behind it in the input register;
// bytes that make no result keep flowing while the result register is full.
// ---------------------------------------------------------------------------
module length_prefixed_frame_receiver (
	input logic          clk,
	input logic          arst_n,
	lpfr_chan_if.sink    rx,
	lpfr_chan_if.source  res,
	lpfr_chan_if.sink    cfg
);
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 advance;
	logic                 fire;
	logic                 can_load;
	logic [7:0]           max_payload_q;
	lpfr_pkg::parse_out_t po;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= lpfr_pkg::MAX_PAYLOAD_RST;
		end else if (cfg.valid) begin
			max_payload_q <= cfg.data;
		end
	end

	assign advance = ~po.has_result | can_load;
	assign fire    = valid_s1 & advance;

	lpfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_byte  (rx.data),
		.in_ready (rx.ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	lpfr_parser u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_s1     (byte_s1),
		.fire        (fire),
		.max_payload (max_payload_q),
		.po          (po)
	);

	lpfr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire & po.has_result),
		.load_data (po.res),
		.can_load  (can_load),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (res.data)
	);
endmodule

// ===== rtl/core/lpfr_checker.sv =====
// ---------------------------------------------------------------------------
// lpfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ---------------------------------------------------------------------------
module lpfr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rx_valid,
	input logic           rx_ready,
	input logic           res_valid,
	input logic           res_ready,
	input lpfr_pkg::res_t res_data
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// a new result needs an earlier byte transfer through the input register
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !$past(res_valid) |-> $past(rx_valid && rx_ready, 2))
		else $error("result without a byte transfer");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.result_kind == lpfr_pkg::KIND_PAYLOAD |->
		res_data.frame_type == 8'd0 && res_data.frame_index == 8'd0 &&
		res_data.frame_length == 8'd0 && !res_data.checksum_ok && !res_data.oversize)
		else $error("payload result carries summary fields");

	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.result_kind == lpfr_pkg::KIND_SUMMARY |->
		res_data.payload_byte == 8'd0 && res_data.payload_offset == 8'd0 &&
		(res_data.checksum_ok || res_data.frame_length != 8'd0))
		else $error("summary result malformed");
endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx.valid),
	.rx_ready  (rx.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives byte streams into the length-prefixed frame receiver. A parse model
// in the bench predicts every forwarded payload byte and frame summary, and each
// result transfer is checked field by field in order. Covers the empty,
// oversize, full-length and limit-change cases, then random framed traffic
// with stray bytes, random sender gaps and result back-pressure.
// ---------------------------------------------------------------------------
module testbench;
	import lpfr_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 700;

	logic clk = 1'b0;
	logic arst_n;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lpfr_chan_if #(.T(logic [7:0])) rx_ch ();
	lpfr_chan_if #(.T(res_t))       res_ch ();
	lpfr_chan_if #(.T(logic [7:0])) cfg_ch ();

	length_prefixed_frame_receiver u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// parse model state
	logic [7:0] max_payload_q;
	phase_t     parse_phase;
	logic [7:0] bytes_left;
	logic [7:0] next_offset;
	logic [7:0] payload_sum;
	logic [7:0] frame_len;
	logic [7:0] frame_type_q;
	logic [7:0] frame_index_q;

	res_t expected_results[$];
	int   errors = 0;
	int   bytes_sent = 0;
	bit   src_idling;
	bit   sink_idling;
	int   stall_left = 0;

	task automatic predict_byte(input logic [7:0] b);
		res_t r;
		r = '0;
		case (parse_phase)
		PH_TYPE: begin
			frame_type_q = b;
			parse_phase = (frame_len != 8'd0) ? PH_DATA : PH_INDEX;
		end
		PH_DATA: begin
			if (next_offset < max_payload_q) begin
				r.result_kind = KIND_PAYLOAD;
				r.payload_byte = b;
				r.payload_offset = next_offset;
				expected_results.push_back(r);
			end
			payload_sum = payload_sum + b;
			next_offset = next_offset + 8'd1;
			bytes_left = bytes_left - 8'd1;
			if (bytes_left == 8'd0)
				parse_phase = PH_INDEX;
		end
		PH_INDEX: begin
			frame_index_q = b;
			parse_phase = PH_CHECK;
		end
		PH_CHECK: begin
			r.result_kind = KIND_SUMMARY;
			r.frame_type = frame_type_q;
			r.frame_index = frame_index_q;
			r.frame_length = frame_len;
			r.checksum_ok = (frame_len == 8'd0) || (payload_sum == b);
			r.oversize = frame_len > max_payload_q;
			expected_results.push_back(r);
			parse_phase = PH_SIZE;
		end
		default: begin
			frame_len = b;
			bytes_left = b;
			next_offset = 8'd0;
			payload_sum = 8'd0;
			parse_phase = PH_TYPE;
		end
		endcase
	endtask

	task automatic put_rx_byte(input logic [7:0] b);
		if (src_idling && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.data <= b;
		do @(posedge clk); while (!rx_ch.ready);
		predict_byte(b);
		bytes_sent++;
	endtask

	task automatic wait_idle();
		rx_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_payload(input logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		max_payload_q = v;
	endtask

	task automatic send_frame(input int len, input logic [7:0] ftype, input logic [7:0] fidx,
			input bit good);
		logic [7:0] sum;
		logic [7:0] b;
		sum = 8'd0;
		put_rx_byte(len[7:0]);
		put_rx_byte(ftype);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			sum = sum + b;
			put_rx_byte(b);
		end
		put_rx_byte(fidx);
		put_rx_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
	endtask

	task automatic check_result(input res_t want, input res_t got);
		if (got.result_kind !== want.result_kind) begin
			$error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
			errors++;
		end
		if (got.payload_byte !== want.payload_byte) begin
			$error("payload_byte: expected %0d, actual %0d", want.payload_byte, got.payload_byte);
			errors++;
		end
		if (got.payload_offset !== want.payload_offset) begin
			$error("payload_offset: expected %0d, actual %0d", want.payload_offset,
				got.payload_offset);
			errors++;
		end
		if (got.frame_type !== want.frame_type) begin
			$error("frame_type: expected %0d, actual %0d", want.frame_type, got.frame_type);
			errors++;
		end
		if (got.frame_index !== want.frame_index) begin
			$error("frame_index: expected %0d, actual %0d", want.frame_index, got.frame_index);
			errors++;
		end
		if (got.frame_length !== want.frame_length) begin
			$error("frame_length: expected %0d, actual %0d", want.frame_length, got.frame_length);
			errors++;
		end
		if (got.checksum_ok !== want.checksum_ok) begin
			$error("checksum_ok: expected %0d, actual %0d", want.checksum_ok, got.checksum_ok);
			errors++;
		end
		if (got.oversize !== want.oversize) begin
			$error("oversize: expected %0d, actual %0d", want.oversize, got.oversize);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: result_kind %0d", res_ch.data.result_kind);
				errors++;
			end else begin
				check_result(expected_results.pop_front(), res_ch.data);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if (sink_idling && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 15);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic test_basic_frames();
		// empty payload passes whatever the checksum byte
		put_rx_byte(8'd0);
		put_rx_byte(8'hFF);
		put_rx_byte(8'h00);
		put_rx_byte(8'hA5);
		// sum wraps to zero
		put_rx_byte(8'd2);
		put_rx_byte(8'h00);
		put_rx_byte(8'hFF);
		put_rx_byte(8'h01);
		put_rx_byte(8'hFF);
		put_rx_byte(8'h00);
		// bad checksum
		put_rx_byte(8'd1);
		put_rx_byte(8'h5A);
		put_rx_byte(8'h00);
		put_rx_byte(8'h01);
		put_rx_byte(8'h55);
	endtask

	task automatic test_zero_limit();
		wait_idle();
		write_max_payload(8'd0);
		put_rx_byte(8'd3);
		put_rx_byte(8'h3C);
		put_rx_byte(8'h80);
		put_rx_byte(8'h7F);
		put_rx_byte(8'h01);
		put_rx_byte(8'hC3);
		put_rx_byte(8'h00);
		send_frame(0, 8'h11, 8'h22, 1'b0);
	endtask

	task automatic test_oversize();
		int limits[4] = '{1, 3, 7, 16};
		foreach (limits[i]) begin
			wait_idle();
			write_max_payload(8'(limits[i]));
			send_frame(limits[i] - 1, 8'($urandom), 8'($urandom), 1'($urandom));
			send_frame(limits[i], 8'($urandom), 8'($urandom), 1'($urandom));
			send_frame(limits[i] + 1, 8'($urandom), 8'($urandom), 1'($urandom));
			send_frame(limits[i] + 5, 8'($urandom), 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic test_limit_change_mid_frame();
		wait_idle();
		write_max_payload(8'd255);
		put_rx_byte(8'd6);
		put_rx_byte(8'($urandom));
		repeat (3) put_rx_byte(8'($urandom));
		wait_idle();
		write_max_payload(8'd2);
		repeat (3) put_rx_byte(8'($urandom));
		put_rx_byte(8'($urandom));
		put_rx_byte(8'($urandom));
		wait_idle();
		write_max_payload(8'd0);
		put_rx_byte(8'd4);
		put_rx_byte(8'($urandom));
		repeat (2) put_rx_byte(8'($urandom));
		wait_idle();
		write_max_payload(8'd255);
		repeat (2) put_rx_byte(8'($urandom));
		put_rx_byte(8'($urandom));
		put_rx_byte(8'($urandom));
	endtask

	task automatic test_full_length();
		wait_idle();
		write_max_payload(8'd255);
		send_frame(255, 8'hFF, 8'hFF, 1'b1);
		wait_idle();
		write_max_payload(8'd254);
		send_frame(255, 8'h00, 8'h00, 1'b1);
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int pick;
		int len;
		stop_at = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				wait_idle();
				case ($urandom_range(0, 3))
				0: write_max_payload(8'd0);
				1: write_max_payload(8'd255);
				2: write_max_payload(8'($urandom_range(1, 16)));
				default: write_max_payload(8'($urandom));
				endcase
			end else if (pick == 1) begin
				// stray bytes, then fill until the parser is back at a size byte
				repeat ($urandom_range(1, 6)) put_rx_byte(8'($urandom));
				while (parse_phase != PH_SIZE) put_rx_byte(8'($urandom));
			end else if (pick == 2) begin
				src_idling = 1'($urandom_range(0, 1));
				sink_idling = 1'($urandom_range(0, 1));
			end else begin
				len = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 255)
					: $urandom_range(0, 12);
				send_frame(len, 8'($urandom), 8'($urandom), $urandom_range(0, 3) != 0);
			end
		end
	endtask

	task automatic test_no_idle();
		src_idling = 1'b0;
		sink_idling = 1'b0;
		wait_idle();
		write_max_payload(8'($urandom_range(0, 12)));
		repeat (20) send_frame($urandom_range(0, 12), 8'($urandom), 8'($urandom),
			1'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.data = 8'd0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 8'd0;
		res_ch.ready = 1'b0;
		src_idling = 1'b1;
		sink_idling = 1'b1;
		max_payload_q = MAX_PAYLOAD_RST;
		parse_phase = PH_SIZE;
		bytes_left = 8'd0;
		next_offset = 8'd0;
		payload_sum = 8'd0;
		frame_len = 8'd0;
		frame_type_q = 8'd0;
		frame_index_q = 8'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_zero_limit();
		test_oversize();
		test_limit_change_mid_frame();
		test_full_length();
		test_random_traffic();
		test_no_idle();

		wait_idle();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/lpfr_pkg.sv
rtl/core/lpfr_chan_if.sv
rtl/core/lpfr_in_stage.sv
rtl/core/lpfr_parser.sv
rtl/core/lpfr_out_reg.sv
rtl/core/length_prefixed_frame_receiver.sv
rtl/core/lpfr_checker.sv
tb/testbench.sv
